// File: sv/ssh_pkg.sv
// Shared types and constants for the speech segment hysteresis unit.
// No dependencies; every other file imports this package.
package ssh_pkg;

    localparam int PROB_W         = 17;
    localparam int PROB_FRAC_BITS = 16;
    localparam int HOP_W          = 17;
    localparam int MAX_HOPS       = 65536;
    localparam int SAMPLE_W       = 27;
    localparam int THR_W          = 17;
    localparam int MIN_HOPS_W     = 10;
    localparam int PAD_W          = 8;
    localparam int HS_W           = 11;
    localparam int HS_MAX         = 1024;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;

    localparam logic [PROB_W:0]    PROB_ONE = (PROB_W + 1)'(1 << PROB_FRAC_BITS);
    localparam logic [HOP_W-1:0]   HOP_LAST = HOP_W'(MAX_HOPS - 1);

    localparam logic [THR_W-1:0]      RST_THRESHOLD   = THR_W'(32768);
    localparam logic [MIN_HOPS_W-1:0] RST_MIN_SPEECH  = MIN_HOPS_W'(8);
    localparam logic [MIN_HOPS_W-1:0] RST_MIN_SILENCE = MIN_HOPS_W'(10);
    localparam logic [PAD_W-1:0]      RST_PAD         = PAD_W'(3);
    localparam logic [HS_W-1:0]       RST_HOP_SAMPLES = HS_W'(160);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD   = 3'd0,
        CFG_MIN_SPEECH  = 3'd1,
        CFG_MIN_SILENCE = 3'd2,
        CFG_PAD         = 3'd3,
        CFG_HOP_SAMPLES = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]      threshold;
        logic [MIN_HOPS_W-1:0] min_speech;
        logic [MIN_HOPS_W-1:0] min_silence;
        logic [PAD_W-1:0]      pad;
        logic [HS_W-1:0]       hop_samples;
    } t_cfg;

    typedef struct packed {
        logic [HOP_W-1:0] seg_start;
        logic [HOP_W-1:0] seg_stop;
    } t_seg;

    typedef struct packed {
        logic             go;
        logic             overflow;
        logic [HOP_W-1:0] hop_count;
    } t_flush_req;

    typedef enum logic [2:0] {
        EM_IDLE,
        EM_READ,
        EM_PAD,
        EM_MUL,
        EM_EMPTY
    } t_emit_state;

endpackage

// File: sv/ssh_if.sv
// Handshake channel interfaces: score input, segment output, register writes.
// Depends on ssh_pkg for field widths.
interface ssh_in_if import ssh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PROB_W-1:0] nonspeech_prob;
    logic              final_score;

    modport source (output valid, nonspeech_prob, final_score, input ready);
    modport sink   (input valid, nonspeech_prob, final_score, output ready);
endinterface

interface ssh_out_if import ssh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] start_sample;
    logic [SAMPLE_W-1:0] end_sample;
    logic                segment_valid;
    logic                table_overflow;
    logic                last_segment;

    modport source (output valid, start_sample, end_sample, segment_valid,
                    table_overflow, last_segment, input ready);
    modport sink   (input valid, start_sample, end_sample, segment_valid,
                    table_overflow, last_segment, output ready);
endinterface

interface ssh_cfg_if import ssh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/ssh_cfg.sv
// Configuration register file for the segmenter.
// Depends on ssh_pkg and ssh_cfg_if.
module ssh_cfg import ssh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssh_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_THRESHOLD:   n_cfg.threshold   = i_cfg.data[THR_W-1:0];
                CFG_MIN_SPEECH:  n_cfg.min_speech  = i_cfg.data[MIN_HOPS_W-1:0];
                CFG_MIN_SILENCE: n_cfg.min_silence = i_cfg.data[MIN_HOPS_W-1:0];
                CFG_PAD:         n_cfg.pad         = i_cfg.data[PAD_W-1:0];
                CFG_HOP_SAMPLES: n_cfg.hop_samples = i_cfg.data[HS_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= RST_THRESHOLD;
            r_cfg.min_speech  <= RST_MIN_SPEECH;
            r_cfg.min_silence <= RST_MIN_SILENCE;
            r_cfg.pad         <= RST_PAD;
            r_cfg.hop_samples <= RST_HOP_SAMPLES;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: sv/ssh_mem.sv
// Segment store: one write port, one registered read port.
// Depends on ssh_pkg for the entry type.
module ssh_mem import ssh_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_seg          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_seg          o_rd_data
);

    t_seg r_mem [DEPTH];
    t_seg r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: sv/ssh_track.sv
// Onset/release hysteresis tracker; writes closed segments to the store.
// Depends on ssh_pkg and ssh_in_if.
module ssh_track import ssh_pkg::*; #(
    parameter int MAX_SEGMENTS = 32,
    parameter int AW           = 5,
    parameter int CW           = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ssh_in_if.sink        i_score,
    input  t_cfg          i_cfg,
    input  logic          i_busy,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_seg          o_wr_data,
    output t_flush_req    o_flush,
    output logic [CW-1:0] o_flush_count
);

    logic             r_in_speech,    n_in_speech;
    logic             r_onset_pend,   n_onset_pend;
    logic [HOP_W-1:0] r_onset_idx,    n_onset_idx;
    logic             r_rel_pend,     n_rel_pend;
    logic [HOP_W-1:0] r_rel_idx,      n_rel_idx;
    logic [HOP_W-1:0] r_open_start,   n_open_start;
    logic [HOP_W-1:0] r_hop,          n_hop;
    logic [CW-1:0]    r_count,        n_count;
    logic             r_dropped,      n_dropped;

    logic             accept;
    logic [PROB_W:0]  score_sum;
    logic             speech;
    logic [HOP_W-1:0] onset_dist;
    logic [HOP_W-1:0] rel_dist;
    logic [HOP_W-1:0] hop_count;
    logic             store_req;
    logic             store_ok;
    t_seg             store_seg;

    assign i_score.ready = !i_busy;
    assign accept        = i_score.valid && !i_busy;
    assign score_sum     = {1'b0, i_score.nonspeech_prob} + {1'b0, i_cfg.threshold};
    assign speech        = score_sum <= PROB_ONE;
    assign onset_dist    = r_hop - r_onset_idx;
    assign rel_dist      = r_hop - r_rel_idx;
    assign hop_count     = r_hop + HOP_W'(1);
    assign store_ok      = r_count < CW'(MAX_SEGMENTS);

    assign o_wr_en       = accept && store_req && store_ok;
    assign o_wr_addr     = r_count[AW-1:0];
    assign o_wr_data     = store_seg;

    always_comb begin
        n_in_speech  = r_in_speech;
        n_onset_pend = r_onset_pend;
        n_onset_idx  = r_onset_idx;
        n_rel_pend   = r_rel_pend;
        n_rel_idx    = r_rel_idx;
        n_open_start = r_open_start;
        n_hop        = r_hop;
        n_count      = r_count;
        n_dropped    = r_dropped;
        store_req    = 1'b0;
        store_seg    = '{seg_start: r_open_start, seg_stop: r_rel_idx};
        o_flush       = '0;
        o_flush_count = r_count;

        if (accept) begin
            if (!r_in_speech) begin
                if (speech) begin
                    if (!r_onset_pend) begin
                        n_onset_pend = 1'b1;
                        n_onset_idx  = r_hop;
                    end else if (onset_dist >= HOP_W'(i_cfg.min_speech)) begin
                        n_in_speech  = 1'b1;
                        n_open_start = r_onset_idx;
                        n_onset_pend = 1'b0;
                    end
                end else begin
                    n_onset_pend = 1'b0;
                end
            end else begin
                if (!speech) begin
                    if (!r_rel_pend) begin
                        n_rel_pend = 1'b1;
                        n_rel_idx  = r_hop;
                    end else if (rel_dist >= HOP_W'(i_cfg.min_silence)) begin
                        n_in_speech = 1'b0;
                        n_rel_pend  = 1'b0;
                        store_req   = 1'b1;
                    end
                end else begin
                    n_rel_pend = 1'b0;
                end
            end

            if (r_hop < HOP_LAST) begin
                n_hop = hop_count;
            end

            // close a segment still open at the last score
            if (i_score.final_score && n_in_speech) begin
                store_req = 1'b1;
                store_seg = '{seg_start: n_open_start, seg_stop: hop_count};
            end

            if (store_req) begin
                if (store_ok) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_dropped = 1'b1;
                end
            end

            if (i_score.final_score) begin
                o_flush.go        = 1'b1;
                o_flush.overflow  = n_dropped;
                o_flush.hop_count = hop_count;
                o_flush_count     = n_count;
                n_in_speech  = 1'b0;
                n_onset_pend = 1'b0;
                n_onset_idx  = '0;
                n_rel_pend   = 1'b0;
                n_rel_idx    = '0;
                n_open_start = '0;
                n_hop        = '0;
                n_count      = '0;
                n_dropped    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_speech  <= 1'b0;
            r_onset_pend <= 1'b0;
            r_onset_idx  <= '0;
            r_rel_pend   <= 1'b0;
            r_rel_idx    <= '0;
            r_open_start <= '0;
            r_hop        <= '0;
            r_count      <= '0;
            r_dropped    <= 1'b0;
        end else begin
            r_in_speech  <= n_in_speech;
            r_onset_pend <= n_onset_pend;
            r_onset_idx  <= n_onset_idx;
            r_rel_pend   <= n_rel_pend;
            r_rel_idx    <= n_rel_idx;
            r_open_start <= n_open_start;
            r_hop        <= n_hop;
            r_count      <= n_count;
            r_dropped    <= n_dropped;
        end
    end

endmodule

// File: sv/ssh_emit.sv
// Flush sequencer: reads stored segments, pads, clamps, scales to samples.
// Depends on ssh_pkg and ssh_out_if; drives the segment store read port.
module ssh_emit import ssh_pkg::*; #(
    parameter int AW = 5,
    parameter int CW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_flush_req    i_flush,
    input  logic [CW-1:0] i_flush_count,
    output logic          o_busy,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  t_seg          i_rd_data,
    ssh_out_if.source     o_seg
);

    localparam int PROD_W = HOP_W + HS_W;

    t_emit_state r_state, n_state;
    logic [AW-1:0]    r_k,     n_k;
    logic [CW-1:0]    r_n,     n_n;
    logic [HOP_W-1:0] r_total, n_total;
    logic             r_ovf,   n_ovf;
    logic [HOP_W-1:0] r_ps,    n_ps;
    logic [HOP_W-1:0] r_pe,    n_pe;

    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_start,     n_start;
    logic [SAMPLE_W-1:0] r_end,       n_end;
    logic                r_segv,      n_segv;
    logic                r_out_ovf,   n_out_ovf;
    logic                r_last,      n_last;

    logic [HS_W-1:0]   hs_eff;
    logic [HOP_W:0]    pe_sum;
    logic [PROD_W-1:0] prod_s;
    logic [PROD_W-1:0] prod_e;
    logic              out_free;
    logic              is_last;

    assign o_busy    = r_state != EM_IDLE;
    assign o_rd_addr = r_k;

    assign o_seg.valid          = r_out_valid;
    assign o_seg.start_sample   = r_start;
    assign o_seg.end_sample     = r_end;
    assign o_seg.segment_valid  = r_segv;
    assign o_seg.table_overflow = r_out_ovf;
    assign o_seg.last_segment   = r_last;

    always_comb begin
        if (i_cfg.hop_samples == '0) begin
            hs_eff = HS_W'(1);
        end else if (i_cfg.hop_samples > HS_W'(HS_MAX)) begin
            hs_eff = HS_W'(HS_MAX);
        end else begin
            hs_eff = i_cfg.hop_samples;
        end
    end

    assign pe_sum   = {1'b0, i_rd_data.seg_stop} + (HOP_W + 1)'(i_cfg.pad);
    assign prod_s   = PROD_W'(r_ps) * PROD_W'(hs_eff);
    assign prod_e   = PROD_W'(r_pe) * PROD_W'(hs_eff);
    assign out_free = !r_out_valid || o_seg.ready;
    assign is_last  = (CW'(r_k) + CW'(1)) == r_n;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_n         = r_n;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_ps        = r_ps;
        n_pe        = r_pe;
        n_out_valid = r_out_valid && !o_seg.ready;
        n_start     = r_start;
        n_end       = r_end;
        n_segv      = r_segv;
        n_out_ovf   = r_out_ovf;
        n_last      = r_last;
        o_rd_en     = 1'b0;

        case (r_state)
            EM_IDLE: begin
                if (i_flush.go) begin
                    n_k     = '0;
                    n_n     = i_flush_count;
                    n_total = i_flush.hop_count;
                    n_ovf   = i_flush.overflow;
                    n_state = (i_flush_count == '0) ? EM_EMPTY : EM_READ;
                end
            end
            EM_READ: begin
                o_rd_en = 1'b1;
                n_state = EM_PAD;
            end
            EM_PAD: begin
                if (i_rd_data.seg_start > HOP_W'(i_cfg.pad)) begin
                    n_ps = i_rd_data.seg_start - HOP_W'(i_cfg.pad);
                end else begin
                    n_ps = '0;
                end
                if (pe_sum > {1'b0, r_total}) begin
                    n_pe = r_total;
                end else begin
                    n_pe = pe_sum[HOP_W-1:0];
                end
                n_state = EM_MUL;
            end
            EM_MUL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_start     = prod_s[SAMPLE_W-1:0];
                    n_end       = prod_e[SAMPLE_W-1:0];
                    n_segv      = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_last      = is_last;
                    if (is_last) begin
                        n_state = EM_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = EM_READ;
                    end
                end
            end
            EM_EMPTY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_start     = '0;
                    n_end       = '0;
                    n_segv      = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_last      = 1'b1;
                    n_state     = EM_IDLE;
                end
            end
            default: begin
                n_state = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EM_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_n       <= n_n;
        r_total   <= n_total;
        r_ovf     <= n_ovf;
        r_ps      <= n_ps;
        r_pe      <= n_pe;
        r_start   <= n_start;
        r_end     <= n_end;
        r_segv    <= n_segv;
        r_out_ovf <= n_out_ovf;
        r_last    <= n_last;
    end

endmodule

// File: sv/speech_segment_hysteresis_unit.sv
// Speech segment hysteresis unit, top level.
// Non-final scores: one per cycle, state updated in the accept cycle, no result.
// Final score: each stored segment passes through the read, pad/clamp and multiply states
// before its word is registered; with no segment, one empty word is registered from the empty state.
// Output stalls hold the sequence; input held off until the last word is loaded.
// Sync active-low reset restores register defaults, clears run state; store is read below count.
module speech_segment_hysteresis_unit import ssh_pkg::*; #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssh_cfg_if.sink    i_cfg,
    ssh_in_if.sink     i_score,
    ssh_out_if.source  o_seg
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    t_cfg          cfg;
    logic          busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_seg          wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_seg          rd_data;
    t_flush_req    flush;
    logic [CW-1:0] flush_count;

    ssh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ssh_track #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .AW           (AW),
        .CW           (CW)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_score       (i_score),
        .i_cfg         (cfg),
        .i_busy        (busy),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_flush       (flush),
        .o_flush_count (flush_count)
    );

    ssh_mem #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ssh_emit #(
        .AW (AW),
        .CW (CW)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_flush       (flush),
        .i_flush_count (flush_count),
        .o_busy        (busy),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_seg         (o_seg)
    );

endmodule

// File: sim/tb_top.sv
// Self-checking bench for speech_segment_hysteresis_unit: score words in, segment words out.
// Uses ssh_pkg and the channel interfaces; an in-bench segment tracker predicts every word.
`timescale 1ns / 1ps

module tb_top import ssh_pkg::*; ();

    localparam int SEG_SLOTS = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] start_sample;
        logic [SAMPLE_W-1:0] end_sample;
        logic                seg_valid;
        logic                overflow;
        logic                is_last;
    } t_seg_word;

    class segment_tracker;
        logic [THR_W-1:0]      thr;
        logic [MIN_HOPS_W-1:0] min_sp;
        logic [MIN_HOPS_W-1:0] min_sil;
        logic [PAD_W-1:0]      pad;
        logic [HS_W-1:0]       hs;

        bit               talking;
        bit               onset_pend;
        bit               release_pend;
        logic [HOP_W-1:0] onset_at;
        logic [HOP_W-1:0] release_at;
        logic [HOP_W-1:0] open_at;
        logic [HOP_W-1:0] hop_at;
        logic [HOP_W-1:0] seg_lo [SEG_SLOTS];
        logic [HOP_W-1:0] seg_hi [SEG_SLOTS];
        int unsigned      seg_fill;
        bit               dropped;

        t_seg_word expected_segments[$];
        int        errors;

        function new();
            thr     = RST_THRESHOLD;
            min_sp  = RST_MIN_SPEECH;
            min_sil = RST_MIN_SILENCE;
            pad     = RST_PAD;
            hs      = RST_HOP_SAMPLES;
            errors  = 0;
            clear_run();
        endfunction

        function void clear_run();
            talking      = 1'b0;
            onset_pend   = 1'b0;
            onset_at     = '0;
            release_pend = 1'b0;
            release_at   = '0;
            open_at      = '0;
            hop_at       = '0;
            seg_fill     = 0;
            dropped      = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_THRESHOLD:   thr     = val[THR_W-1:0];
                CFG_MIN_SPEECH:  min_sp  = val[MIN_HOPS_W-1:0];
                CFG_MIN_SILENCE: min_sil = val[MIN_HOPS_W-1:0];
                CFG_PAD:         pad     = val[PAD_W-1:0];
                CFG_HOP_SAMPLES: hs      = val[HS_W-1:0];
                default: ;
            endcase
        endfunction

        function void keep_segment(logic [HOP_W-1:0] s, logic [HOP_W-1:0] e);
            if (seg_fill < SEG_SLOTS) begin
                seg_lo[seg_fill] = s;
                seg_hi[seg_fill] = e;
                seg_fill++;
            end else begin
                dropped = 1'b1;
            end
        endfunction

        function void note_score(logic [PROB_W-1:0] prob, logic fin);
            int          score;
            bit          speech;
            logic [HOP_W-1:0] i;
            logic [HOP_W-1:0] count;
            int unsigned hs_eff;
            int unsigned ps;
            int unsigned pe;
            t_seg_word   w;
            score  = int'(PROB_ONE) - int'(prob);
            speech = (score >= int'(thr));
            i      = hop_at;
            if (!talking) begin
                if (speech) begin
                    if (!onset_pend) begin
                        onset_pend = 1'b1;
                        onset_at   = i;
                    end else if ((i - onset_at) >= min_sp) begin
                        talking    = 1'b1;
                        open_at    = onset_at;
                        onset_pend = 1'b0;
                    end
                end else begin
                    onset_pend = 1'b0;
                end
            end else begin
                if (!speech) begin
                    if (!release_pend) begin
                        release_pend = 1'b1;
                        release_at   = i;
                    end else if ((i - release_at) >= min_sil) begin
                        talking = 1'b0;
                        keep_segment(open_at, release_at);
                        release_pend = 1'b0;
                    end
                end else begin
                    release_pend = 1'b0;
                end
            end
            if (hop_at < HOP_LAST) hop_at++;
            if (!fin) return;

            count = i + 1'b1;
            if (talking) keep_segment(open_at, count);
            hs_eff = hs;
            if (hs_eff == 0) hs_eff = 1;
            if (hs_eff > HS_MAX) hs_eff = HS_MAX;
            if (seg_fill == 0) begin
                w = '0;
                w.overflow = dropped;
                w.is_last  = 1'b1;
                expected_segments.push_back(w);
            end else begin
                for (int k = 0; k < seg_fill; k++) begin
                    ps = (seg_lo[k] > pad) ? seg_lo[k] - pad : 0;
                    pe = seg_hi[k] + pad;
                    if (pe > count) pe = count;
                    w.start_sample = SAMPLE_W'(ps * hs_eff);
                    w.end_sample   = SAMPLE_W'(pe * hs_eff);
                    w.seg_valid    = 1'b1;
                    w.overflow     = dropped;
                    w.is_last      = (k + 1 == seg_fill);
                    expected_segments.push_back(w);
                end
            end
            clear_run();
        endfunction

        function void check_segment(t_seg_word got);
            t_seg_word want;
            if (expected_segments.size() == 0) begin
                $display("%0t: unexpected segment word start %0d end %0d valid %0b ovf %0b last %0b",
                         $time, got.start_sample, got.end_sample, got.seg_valid,
                         got.overflow, got.is_last);
                errors++;
                return;
            end
            want = expected_segments.pop_front();
            if (got !== want) begin
                $display("%0t: segment mismatch expected start %0d end %0d valid %0b ovf %0b last %0b",
                         $time, want.start_sample, want.end_sample, want.seg_valid,
                         want.overflow, want.is_last);
                $display("%0t:                  actual   start %0d end %0d valid %0b ovf %0b last %0b",
                         $time, got.start_sample, got.end_sample, got.seg_valid,
                         got.overflow, got.is_last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_segments.size();
        endfunction
    endclass

    bit   i_clk;
    logic i_rst_n;

    ssh_cfg_if cfg_bus ();
    ssh_in_if  score_bus ();
    ssh_out_if seg_bus ();

    speech_segment_hysteresis_unit #(
        .MAX_SEGMENTS(SEG_SLOTS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_bus),
        .i_score(score_bus),
        .o_seg  (seg_bus)
    );

    segment_tracker sb = new();

    int feed_calm       = 0;
    int drain_calm      = 0;
    int hold_left       = 0;
    bit long_hold_done  = 1'b0;
    int items_sent      = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_bus.ready <= 1'b0;
        end else begin
            if (seg_bus.valid && seg_bus.ready) begin
                sb.check_segment({seg_bus.start_sample, seg_bus.end_sample, seg_bus.segment_valid,
                                  seg_bus.table_overflow, seg_bus.last_segment});
                if (!long_hold_done && sb.pending() >= 8) begin
                    hold_left      = 300;
                    long_hold_done = 1'b1;
                end else begin
                    hold_left = draw_wait(drain_calm);
                end
            end
            if (hold_left > 0) begin
                seg_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                seg_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_score(input logic [PROB_W-1:0] prob, input logic fin);
        int gap;
        gap = draw_wait(feed_calm);
        if (gap > 0) begin
            score_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        score_bus.valid          <= 1'b1;
        score_bus.nonspeech_prob <= prob;
        score_bus.final_score    <= fin;
        @(posedge i_clk);
        while (!score_bus.ready) @(posedge i_clk);
        sb.note_score(prob, fin);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_config(input logic [THR_W-1:0] thr, input logic [MIN_HOPS_W-1:0] msp,
                              input logic [MIN_HOPS_W-1:0] msil, input logic [PAD_W-1:0] pad,
                              input logic [HS_W-1:0] hs);
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_MIN_SPEECH, CFG_DATA_W'(msp));
        write_reg(CFG_MIN_SILENCE, CFG_DATA_W'(msil));
        write_reg(CFG_PAD, CFG_DATA_W'(pad));
        write_reg(CFG_HOP_SAMPLES, CFG_DATA_W'(hs));
        cfg_bus.valid <= 1'b0;
    endtask

    // hold until every predicted word is out, then let the pipeline settle
    task automatic drain_segments();
        score_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [PROB_W-1:0] speech_prob();
        int top;
        top = int'(PROB_ONE) - int'(sb.thr);
        if (top < 0) return '0;
        if ($urandom_range(0, 7) == 0) return PROB_W'(top);
        return PROB_W'($urandom_range(0, top));
    endfunction

    function automatic logic [PROB_W-1:0] quiet_prob();
        int lo;
        lo = int'(PROB_ONE) - int'(sb.thr) + 1;
        if (lo < 0) lo = 0;
        if ($urandom_range(0, 7) == 0) return PROB_W'(lo);
        return PROB_W'($urandom_range(lo, (1 << PROB_W) - 1));
    endfunction

    task automatic run_utterance(input int len);
        bit               voiced;
        int               run_left;
        logic [PROB_W-1:0] p;
        voiced   = $urandom_range(0, 1);
        run_left = 0;
        for (int n = 0; n < len; n++) begin
            if (run_left == 0) begin
                voiced   = !voiced;
                run_left = $urandom_range(1, (voiced ? int'(sb.min_sp) : int'(sb.min_sil)) + 3);
            end
            if ($urandom_range(0, 9) == 0)
                p = PROB_W'($urandom_range(0, (1 << PROB_W) - 1));
            else
                p = voiced ? speech_prob() : quiet_prob();
            send_score(p, n == len - 1);
            run_left--;
        end
    endtask

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int               rand_base;
        int               phase_goal;
        logic [THR_W-1:0] thr;

        i_rst_n                  <= 1'b0;
        cfg_bus.valid            <= 1'b0;
        cfg_bus.index            <= '0;
        cfg_bus.data             <= '0;
        score_bus.valid          <= 1'b0;
        score_bus.nonspeech_prob <= '0;
        score_bus.final_score    <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: empty utterance, then one segment on the threshold boundary
        send_score('0, 1'b1);
        for (int k = 0; k < 10; k++) send_score((k % 2) ? PROB_W'(32768) : PROB_W'(0), 1'b0);
        for (int k = 0; k < 12; k++)
            send_score((k % 3 == 0) ? PROB_W'(32769) : (k % 3 == 1) ? PROB_W'(65536)
                                                                     : PROB_W'(131071), 1'b0);
        send_score(PROB_W'(65536), 1'b1);
        drain_segments();

        // store overflow with pads clamped at zero and at the hop count
        set_config(THR_W'(65536), '0, '0, PAD_W'(255), HS_W'(1024));
        for (int r = 0; r < 35; r++) begin
            send_score('0, 1'b0);
            send_score('0, 1'b0);
            send_score(PROB_W'(1), 1'b0);
            send_score(PROB_W'(1), 1'b0);
        end
        send_score('0, 1'b0);
        send_score('0, 1'b0);
        send_score('0, 1'b1);
        run_utterance(6);
        drain_segments();

        // threshold above one: nothing is ever speech
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        set_config(THR_W'(131071), MIN_HOPS_W'(1023), MIN_HOPS_W'(1023), '0, '0);
        send_score('0, 1'b0);
        send_score('0, 1'b0);
        send_score(PROB_W'(65536), 1'b1);
        drain_segments();

        rand_base = items_sent;
        while (items_sent - rand_base < 100) begin
            case ($urandom_range(0, 9))
                7:       thr = THR_W'($urandom_range(0, 65536));
                8:       thr = THR_W'($urandom);
                9:       thr = '0;
                default: thr = THR_W'($urandom_range(16384, 49152));
            endcase
            set_config(thr,
                       MIN_HOPS_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 40)
                                                                : $urandom_range(0, 6)),
                       MIN_HOPS_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 40)
                                                                : $urandom_range(0, 6)),
                       PAD_W'($urandom_range(0, 255)),
                       HS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                          : $urandom_range(1, 1024)));
            phase_goal = items_sent + $urandom_range(30, 70);
            while (items_sent < phase_goal) run_utterance($urandom_range(1, 40));
            drain_segments();
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
